// ===== sv/rnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnr_pkg: shared types and constants of the RTP H.264 NAL reassembler
// Frame buffer geometry, NAL type codes, result slot codes and the command
// word that travels from the parser to the result sequencer.
// ----------------------------------------------------------------------------
package rnr_pkg;

  // Frame buffer geometry
  localparam int unsigned FRAME_BYTES = 524288;
  localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);
  localparam int unsigned SUM_W       = FILL_W + 1;

  // Packet field widths
  localparam int unsigned LEN_W = 16;
  localparam int unsigned TS_W  = 32;

  // Command queue geometry
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // NAL unit type codes
  localparam logic [4:0] NAL_TYPE_MAX_SINGLE = 5'd23;
  localparam logic [4:0] NAL_STAP_A          = 5'd24;
  localparam logic [4:0] NAL_FU_A            = 5'd28;
  localparam logic [4:0] NAL_FU_B            = 5'd29;
  localparam logic [4:0] NAL_IDR             = 5'd5;
  localparam logic [4:0] NAL_SPS             = 5'd7;
  localparam logic [4:0] NAL_PPS             = 5'd8;
  localparam logic [7:0] NRI_MASK            = 8'h60;

  // Result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DESC  = 1'b1;

  // Result slots of one command, emitted lowest first
  localparam int unsigned NSLOTS    = 7;
  localparam int unsigned SLOT_W    = $clog2(NSLOTS);
  localparam logic [SLOT_W-1:0] SLOT_PRE  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_SC0  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_SC3  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_BYTE = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_POST = 3'd6;

  typedef struct packed {
    logic [NSLOTS-1:0] slots;
    logic              sc;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wbyte;
    logic [FILL_W-1:0] pre_len;
    logic [TS_W-1:0]   pre_ts;
    logic              pre_key;
    logic [FILL_W-1:0] post_len;
    logic [TS_W-1:0]   post_ts;
    logic              post_key;
  } cmd_t;

  function automatic logic is_key(input logic [4:0] t);
    return (t == NAL_IDR) || (t == NAL_SPS) || (t == NAL_PPS);
  endfunction

endpackage

// ===== sv/rnr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnr_parser: payload byte parser
// Classifies packets, tracks fill, key flag and timestamp, and turns each
// accepted byte into one command word listing the results it causes.
// ----------------------------------------------------------------------------
module rnr_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  payload_byte_i,
  input  logic                        packet_start_i,
  input  logic [rnr_pkg::LEN_W-1:0]   payload_length_i,
  input  logic [rnr_pkg::TS_W-1:0]    rtp_timestamp_i,
  input  logic                        marker_bit_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output rnr_pkg::cmd_t               q_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FU_HDR, PH_STAP_HI, PH_STAP_LO, PH_DATA, PH_TAIL, PH_FU_DATA, PH_QUIET
  } phase_e;

  localparam int unsigned QW = rnr_pkg::LEN_W + 2;

  phase_e                      phase_q, phase_d;
  logic [rnr_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic [rnr_pkg::TS_W-1:0]    prev_ts_q, prev_ts_d;
  logic                        frag_q, frag_d;
  logic                        key_q, key_d;
  logic [rnr_pkg::LEN_W-1:0]   pos_q, pos_d;
  logic [rnr_pkg::LEN_W-1:0]   rem_q, rem_d;
  logic [7:0]                  ind_q, ind_d;
  logic                        drop_q, drop_d;
  logic [rnr_pkg::LEN_W-1:0]   len_q, len_d;
  logic [rnr_pkg::TS_W-1:0]    ts_q, ts_d;
  logic                        mk_q, mk_d;
  logic                        fu_end_q, fu_end_d;
  logic                        head_q, head_d;
  rnr_pkg::cmd_t               cmd;
  logic                        accept;

  function automatic phase_e next_unit(input logic [QW-1:0] q,
                                       input logic [rnr_pkg::LEN_W-1:0] len);
    return ((q + QW'(2)) < QW'(len)) ? PH_STAP_HI : PH_TAIL;
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept && (cmd.slots != '0);
  assign q_data_o   = cmd;

  // Parse one byte: next state and the command it produces
  always_comb begin
    logic [7:0]                  b;
    logic [4:0]                  t;
    logic                        done;
    logic [rnr_pkg::LEN_W-1:0]   ulen;
    logic [rnr_pkg::SUM_W-1:0]   need;
    logic                        do_ts;
    logic                        do_sc;
    logic                        do_wb;
    logic                        do_fin;
    logic [QW-1:0]               span;
    b        = payload_byte_i;
    t        = payload_byte_i[4:0];
    done     = 1'b0;
    ulen     = '0;
    need     = '0;
    do_ts    = 1'b0;
    do_sc    = 1'b0;
    do_wb    = 1'b0;
    do_fin   = 1'b0;
    span     = '0;
    phase_d  = phase_q;
    fill_d   = fill_q;
    prev_ts_d = prev_ts_q;
    frag_d   = frag_q;
    key_d    = key_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    ind_d    = ind_q;
    drop_d   = drop_q;
    len_d    = len_q;
    ts_d     = ts_q;
    mk_d     = mk_q;
    fu_end_d = fu_end_q;
    head_d   = head_q;
    cmd      = '0;

    // Decide what this byte does
    if (packet_start_i) begin
      len_d = payload_length_i;
      ts_d  = rtp_timestamp_i;
      mk_d  = marker_bit_i;
      pos_d = '0;
      if (payload_length_i == '0) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else if (t == rnr_pkg::NAL_STAP_A) begin
        do_ts   = 1'b1;
        phase_d = next_unit(QW'(1), payload_length_i);
      end else if (t == rnr_pkg::NAL_FU_A || t == rnr_pkg::NAL_FU_B) begin
        ind_d   = b;
        phase_d = (payload_length_i < rnr_pkg::LEN_W'(2)) ? PH_QUIET : PH_FU_HDR;
      end else if (t != 5'd0 && t <= rnr_pkg::NAL_TYPE_MAX_SINGLE) begin
        do_ts   = 1'b1;
        head_d  = 1'b0;
        rem_d   = payload_length_i - rnr_pkg::LEN_W'(1);
        phase_d = PH_DATA;
      end else begin
        phase_d = PH_QUIET;
      end
    end else if (phase_q == PH_IDLE) begin
      done = 1'b1;
    end else begin
      pos_d = pos_q + rnr_pkg::LEN_W'(1);
    end

    // Timestamp change closes the old frame
    if (accept && do_ts) begin
      if (ts_d != prev_ts_q && fill_d != '0) begin
        cmd.slots[rnr_pkg::SLOT_PRE] = 1'b1;
        cmd.pre_len = fill_d;
        cmd.pre_ts  = prev_ts_q;
        cmd.pre_key = key_d;
        fill_d = '0;
        key_d  = 1'b0;
      end
      prev_ts_d = ts_d;
    end

    // Single NAL unit head
    if (packet_start_i && !done && phase_d == PH_DATA) begin
      need = rnr_pkg::SUM_W'(fill_d) + rnr_pkg::SUM_W'(4) + rnr_pkg::SUM_W'(len_d);
      if (need > rnr_pkg::SUM_W'(rnr_pkg::FRAME_BYTES)) begin
        drop_d = 1'b1;
      end else begin
        drop_d = 1'b0;
        do_sc  = 1'b1;
        do_wb  = 1'b1;
        cmd.wbyte = b;
        if (rnr_pkg::is_key(t)) key_d = 1'b1;
      end
    end

    // Body bytes
    if (!packet_start_i && !done) begin
      unique case (phase_q)
        PH_FU_HDR: begin
          if (b[7]) begin
            if (ts_d != prev_ts_q && fill_d != '0) begin
              cmd.slots[rnr_pkg::SLOT_PRE] = 1'b1;
              cmd.pre_len = fill_d;
              cmd.pre_ts  = prev_ts_q;
              cmd.pre_key = key_d;
              fill_d = '0;
              key_d  = 1'b0;
            end
            prev_ts_d = ts_d;
            need = rnr_pkg::SUM_W'(fill_d) + rnr_pkg::SUM_W'(5);
            if (need > rnr_pkg::SUM_W'(rnr_pkg::FRAME_BYTES)) begin
              frag_d = 1'b0;
            end else begin
              frag_d = 1'b1;
              do_sc  = 1'b1;
              do_wb  = 1'b1;
              cmd.wbyte = (ind_q & rnr_pkg::NRI_MASK) | {3'b000, t};
              if (rnr_pkg::is_key(t)) key_d = 1'b1;
            end
          end
          need = rnr_pkg::SUM_W'(fill_d) + (do_sc ? rnr_pkg::SUM_W'(5) : '0)
               + rnr_pkg::SUM_W'(len_q - rnr_pkg::LEN_W'(2));
          if (!frag_d) begin
            phase_d = PH_QUIET;
          end else if (need > rnr_pkg::SUM_W'(rnr_pkg::FRAME_BYTES)) begin
            frag_d  = 1'b0;
            phase_d = PH_QUIET;
          end else begin
            fu_end_d = b[6];
            phase_d  = PH_FU_DATA;
          end
        end
        PH_FU_DATA: begin
          do_wb     = 1'b1;
          cmd.wbyte = b;
        end
        PH_STAP_HI: begin
          rem_d   = {b, 8'h00};
          phase_d = PH_STAP_LO;
        end
        PH_STAP_LO: begin
          ulen = {rem_q[15:8], b};
          span = QW'(pos_d) + QW'(1) + QW'(ulen);
          if (span > QW'(len_q)) begin
            phase_d = PH_TAIL;
          end else begin
            need = rnr_pkg::SUM_W'(fill_d) + rnr_pkg::SUM_W'(4) + rnr_pkg::SUM_W'(ulen);
            if (need > rnr_pkg::SUM_W'(rnr_pkg::FRAME_BYTES)) begin
              drop_d = 1'b1;
            end else begin
              drop_d = 1'b0;
              do_sc  = 1'b1;
            end
            if (ulen == '0) begin
              phase_d = next_unit(QW'(pos_d) + QW'(1), len_q);
            end else begin
              rem_d   = ulen;
              head_d  = 1'b1;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (rem_q == '0) begin
            phase_d = PH_TAIL;
          end else begin
            if (!drop_q) begin
              do_wb     = 1'b1;
              cmd.wbyte = b;
              if (head_q && rnr_pkg::is_key(t)) key_d = 1'b1;
            end
            head_d = 1'b0;
            rem_d  = rem_q - rnr_pkg::LEN_W'(1);
            if (rem_d == '0) phase_d = next_unit(QW'(pos_d) + QW'(1), len_q);
          end
        end
        default: begin
        end
      endcase
    end

    // Place the writes
    cmd.sc   = do_sc;
    cmd.addr = rnr_pkg::ADDR_W'(fill_d);
    cmd.slots[rnr_pkg::SLOT_SC0 +: 4] = {4{do_sc}};
    cmd.slots[rnr_pkg::SLOT_BYTE]     = do_wb;
    fill_d = fill_d + (do_sc ? rnr_pkg::FILL_W'(4) : '0)
                    + (do_wb ? rnr_pkg::FILL_W'(1) : '0);

    // Packet end: marker closes the frame
    if (!done && (QW'(pos_d) + QW'(1) >= QW'(len_d))) begin
      if (phase_d == PH_STAP_HI || phase_d == PH_STAP_LO || phase_d == PH_DATA ||
          phase_d == PH_TAIL) begin
        do_fin = mk_d;
      end else if (phase_d == PH_FU_DATA && fu_end_d) begin
        frag_d = 1'b0;
        do_fin = mk_d;
      end
      phase_d = PH_IDLE;
    end
    if (do_fin) begin
      if (fill_d != '0) begin
        cmd.slots[rnr_pkg::SLOT_POST] = 1'b1;
        cmd.post_len = fill_d;
        cmd.post_ts  = ts_d;
        cmd.post_key = key_d;
      end
      fill_d = '0;
      key_d  = 1'b0;
    end
  end

  // Hold parser state; advance on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fill_q    <= '0;
      prev_ts_q <= '0;
      frag_q    <= 1'b0;
      key_q     <= 1'b0;
      pos_q     <= '0;
      rem_q     <= '0;
      ind_q     <= '0;
      drop_q    <= 1'b0;
      len_q     <= '0;
      ts_q      <= '0;
      mk_q      <= 1'b0;
      fu_end_q  <= 1'b0;
      head_q    <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      fill_q    <= fill_d;
      prev_ts_q <= prev_ts_d;
      frag_q    <= frag_d;
      key_q     <= key_d;
      pos_q     <= pos_d;
      rem_q     <= rem_d;
      ind_q     <= ind_d;
      drop_q    <= drop_d;
      len_q     <= len_d;
      ts_q      <= ts_d;
      mk_q      <= mk_d;
      fu_end_q  <= fu_end_d;
      head_q    <= head_d;
    end
  end

endmodule

// ===== sv/rnr_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnr_cmd_queue: command queue
// Short queue of command words between the parser and the sequencer.
// ----------------------------------------------------------------------------
module rnr_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rnr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rnr_pkg::cmd_t data_o
);

  rnr_pkg::cmd_t                mem_q [rnr_pkg::CMDQ_DEPTH];
  logic [rnr_pkg::CMDQ_AW-1:0]  wptr_q, rptr_q;
  logic [rnr_pkg::CMDQ_CW-1:0]  count_q;

  assign full_o  = (count_q == rnr_pkg::CMDQ_CW'(rnr_pkg::CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + rnr_pkg::CMDQ_AW'(1);
      if (pop_i)  rptr_q <= rptr_q + rnr_pkg::CMDQ_AW'(1);
      if (push_i && !pop_i)      count_q <= count_q + rnr_pkg::CMDQ_CW'(1);
      else if (pop_i && !push_i) count_q <= count_q - rnr_pkg::CMDQ_CW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + rnr_pkg::CMDQ_CW'(1))
    else $error("command queue count slip");
  a_no_empty_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> data_i.slots != '0)
    else $error("command with no results queued");
`endif

endmodule

// ===== sv/rnr_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnr_sequencer: result sequencer
// Expands command words into one result beat per cycle, while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module rnr_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  rnr_pkg::cmd_t               q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [rnr_pkg::ADDR_W-1:0]  write_address_o,
  output logic [7:0]                  write_byte_o,
  output logic [rnr_pkg::FILL_W-1:0]  frame_length_o,
  output logic [rnr_pkg::TS_W-1:0]    frame_timestamp_o,
  output logic                        key_frame_o,
  output logic                        last_o
);

  rnr_pkg::cmd_t                cur_q;
  logic [rnr_pkg::NSLOTS-1:0]   mask_q;
  rnr_pkg::cmd_t                sel;
  logic [rnr_pkg::NSLOTS-1:0]   sel_mask, rest;
  logic [rnr_pkg::SLOT_W-1:0]   idx;
  logic                         advance, emit, from_q;
  logic                         out_valid_q;

  assign from_q   = (mask_q == '0);
  assign sel      = from_q ? q_data_i : cur_q;
  assign sel_mask = from_q ? (q_valid_i ? q_data_i.slots : '0) : mask_q;
  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = (sel_mask != '0);
  assign q_pop_o  = advance && from_q && q_valid_i;
  assign out_valid_o = out_valid_q;

  // Pick the lowest pending slot
  always_comb begin
    idx = '0;
    for (int i = rnr_pkg::NSLOTS - 1; i >= 0; i--) begin
      if (sel_mask[i]) idx = rnr_pkg::SLOT_W'(i);
    end
    rest = sel_mask & ~(rnr_pkg::NSLOTS'(1) << idx);
  end

  // Hold the command under expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (advance && emit) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) cur_q <= sel;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      last_o            <= (rest == '0);
      kind_o            <= rnr_pkg::KIND_WRITE;
      write_address_o   <= '0;
      write_byte_o      <= '0;
      frame_length_o    <= '0;
      frame_timestamp_o <= '0;
      key_frame_o       <= 1'b0;
      if (idx == rnr_pkg::SLOT_PRE) begin
        kind_o            <= rnr_pkg::KIND_DESC;
        frame_length_o    <= sel.pre_len;
        frame_timestamp_o <= sel.pre_ts;
        key_frame_o       <= sel.pre_key;
      end else if (idx == rnr_pkg::SLOT_POST) begin
        kind_o            <= rnr_pkg::KIND_DESC;
        frame_length_o    <= sel.post_len;
        frame_timestamp_o <= sel.post_ts;
        key_frame_o       <= sel.post_key;
      end else if (idx == rnr_pkg::SLOT_BYTE) begin
        write_address_o <= sel.addr + (sel.sc ? rnr_pkg::ADDR_W'(4) : '0);
        write_byte_o    <= sel.wbyte;
      end else begin
        write_address_o <= sel.addr + rnr_pkg::ADDR_W'(idx - rnr_pkg::SLOT_SC0);
        write_byte_o    <= (idx == rnr_pkg::SLOT_SC3) ? 8'h01 : 8'h00;
      end
    end
  end

endmodule

// ===== sv/rtp_h264_nal_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_h264_nal_reassembler: RTP H.264 payload to Annex B frame writer
// Parser, command queue and result sequencer.
// ----------------------------------------------------------------------------
// The block takes one payload byte per beat and accepts a new byte in every
// cycle while its two-entry command queue has room. Each byte causes zero to
// seven results (frame buffer writes and frame descriptors), which leave one
// per cycle from a registered output while the output is not stalled. The
// parser can take new bytes while the sequencer still expands older ones.
// The result sequencer sets the sustained rate.
module rtp_h264_nal_reassembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  payload_byte_i,
  input  logic                        packet_start_i,
  input  logic [rnr_pkg::LEN_W-1:0]   payload_length_i,
  input  logic [rnr_pkg::TS_W-1:0]    rtp_timestamp_i,
  input  logic                        marker_bit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [rnr_pkg::ADDR_W-1:0]  write_address_o,
  output logic [7:0]                  write_byte_o,
  output logic [rnr_pkg::FILL_W-1:0]  frame_length_o,
  output logic [rnr_pkg::TS_W-1:0]    frame_timestamp_o,
  output logic                        key_frame_o,
  output logic                        last_o
);

  logic          q_push, q_full, q_pop, q_valid;
  rnr_pkg::cmd_t q_wdata, q_rdata;

  rnr_parser u_parser (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .payload_byte_i, .packet_start_i, .payload_length_i, .rtp_timestamp_i,
    .marker_bit_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  rnr_cmd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  rnr_sequencer u_seq (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .kind_o, .write_address_o, .write_byte_o,
    .frame_length_o, .frame_timestamp_o, .key_frame_o, .last_o
  );

endmodule

// ===== tb/sv/rtp_h264_nal_reassembler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_h264_nal_reassembler_tb: self-checking bench for the NAL reassembler
// Feeds directed and random RTP packets (single NAL, STAP-A, FU-A/FU-B,
// ignored types, broken packets) byte by byte. A behavioral predictor works
// out the frame writes and descriptors of each byte, and every output beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rtp_h264_nal_reassembler_tb;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FU_HDR, PH_STAP_HI, PH_STAP_LO, PH_DATA, PH_TAIL, PH_FU_DATA, PH_QUIET
  } phase_e;

  typedef struct packed {
    logic                       kind;
    logic [rnr_pkg::ADDR_W-1:0] addr;
    logic [7:0]                 wbyte;
    logic [rnr_pkg::FILL_W-1:0] flen;
    logic [rnr_pkg::TS_W-1:0]   ts;
    logic                       key;
    logic                       last;
  } beat_t;

  typedef struct packed {
    logic [7:0]                b;
    logic                      start;
    logic [rnr_pkg::LEN_W-1:0] len;
    logic [rnr_pkg::TS_W-1:0]  ts;
    logic                      marker;
  } byte_t;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_stall_o;
  logic [7:0] payload_byte_i = '0;
  logic packet_start_i = 1'b0;
  logic [rnr_pkg::LEN_W-1:0] payload_length_i = '0;
  logic [rnr_pkg::TS_W-1:0] rtp_timestamp_i = '0;
  logic marker_bit_i = 1'b0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic kind_o, key_frame_o, last_o;
  logic [rnr_pkg::ADDR_W-1:0] write_address_o;
  logic [7:0] write_byte_o;
  logic [rnr_pkg::FILL_W-1:0] frame_length_o;
  logic [rnr_pkg::TS_W-1:0] frame_timestamp_o;

  rtp_h264_nal_reassembler u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  int unsigned fill, prev_ts, rem, pos, plen, pts, ind;
  logic frag_on, key_on, drop, pmark, fu_end, head;
  phase_e ph;
  beat_t frame_q[$];
  beat_t step_q[$];
  byte_t pkt_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rx = 0;

  function automatic bit key_type(int unsigned t);
    return t == rnr_pkg::NAL_IDR || t == rnr_pkg::NAL_SPS || t == rnr_pkg::NAL_PPS;
  endfunction

  function automatic void emit(logic k, int unsigned a, int unsigned v, int unsigned l,
                               int unsigned ts, logic key);
    beat_t r;
    r.kind = k; r.addr = rnr_pkg::ADDR_W'(a); r.wbyte = 8'(v);
    r.flen = rnr_pkg::FILL_W'(l); r.ts = ts; r.key = key; r.last = 0;
    step_q.push_back(r);
  endfunction

  function automatic void put_byte(int unsigned v);
    emit(rnr_pkg::KIND_WRITE, fill, v, 0, 0, 0);
    fill++;
  endfunction

  function automatic void put_start_code();
    put_byte(0); put_byte(0); put_byte(0); put_byte(1);
  endfunction

  function automatic void close_frame(int unsigned ts);
    if (fill > 0) emit(rnr_pkg::KIND_DESC, 0, 0, fill, ts, key_on);
    fill = 0;
    key_on = 0;
  endfunction

  function automatic void check_ts();
    if (pts != prev_ts && fill > 0) close_frame(prev_ts);
    prev_ts = pts;
  endfunction

  function automatic void next_unit(int unsigned q);
    ph = (q + 2 < plen) ? PH_STAP_HI : PH_TAIL;
  endfunction

  // Work out the results of one accepted byte and queue them
  function automatic void predict_frame(byte_t x);
    int unsigned b, t, L;
    b = 32'(x.b); t = b & 'h1F;
    step_q = {};
    if (x.start) begin
      plen = 32'(x.len); pts = x.ts; pmark = x.marker; pos = 0;
      if (plen == 0) begin
        ph = PH_IDLE;
        return;
      end
      if (t == rnr_pkg::NAL_STAP_A) begin
        check_ts(); next_unit(1);
      end else if (t == rnr_pkg::NAL_FU_A || t == rnr_pkg::NAL_FU_B) begin
        ind = b; ph = (plen < 2) ? PH_QUIET : PH_FU_HDR;
      end else if (t >= 1 && t <= rnr_pkg::NAL_TYPE_MAX_SINGLE) begin
        check_ts();
        if (fill + 4 + plen > rnr_pkg::FRAME_BYTES) drop = 1;
        else begin
          drop = 0; put_start_code(); put_byte(b);
          if (key_type(t)) key_on = 1;
        end
        head = 0; rem = plen - 1; ph = PH_DATA;
      end else ph = PH_QUIET;
    end else begin
      if (ph == PH_IDLE) return;
      pos++;
      case (ph)
        PH_FU_HDR: begin
          if (b & 'h80) begin
            check_ts();
            if (fill + 5 > rnr_pkg::FRAME_BYTES) frag_on = 0;
            else begin
              frag_on = 1; put_start_code(); put_byte((ind & rnr_pkg::NRI_MASK) | t);
              if (key_type(t)) key_on = 1;
            end
          end
          if (!frag_on) ph = PH_QUIET;
          else if (fill + (plen - 2) > rnr_pkg::FRAME_BYTES) begin
            frag_on = 0; ph = PH_QUIET;
          end else begin
            fu_end = (b & 'h40) != 0; ph = PH_FU_DATA;
          end
        end
        PH_FU_DATA: put_byte(b);
        PH_STAP_HI: begin
          rem = b << 8; ph = PH_STAP_LO;
        end
        PH_STAP_LO: begin
          L = rem | b;
          if (pos + 1 + L > plen) ph = PH_TAIL;
          else begin
            if (fill + 4 + L > rnr_pkg::FRAME_BYTES) drop = 1;
            else begin
              drop = 0; put_start_code();
            end
            if (L == 0) next_unit(pos + 1);
            else begin
              rem = L; head = 1; ph = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (rem == 0) ph = PH_TAIL;
          else begin
            if (!drop) begin
              put_byte(b);
              if (head && key_type(t)) key_on = 1;
            end
            head = 0; rem--;
            if (rem == 0) next_unit(pos + 1);
          end
        end
        default: ;
      endcase
    end
    if (pos + 1 >= plen) begin
      if (ph >= PH_STAP_HI && ph <= PH_TAIL) begin
        if (pmark) close_frame(pts);
      end else if (ph == PH_FU_DATA && fu_end) begin
        frag_on = 0;
        if (pmark) close_frame(pts);
      end
      ph = PH_IDLE;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
    foreach (step_q[i]) frame_q.push_back(step_q[i]);
  endfunction

  // Packet builders: append one packet's bytes to the send list
  task automatic add_pkt(input logic [7:0] data[$], input int unsigned ts, input logic mk);
    byte_t x;
    foreach (data[i]) begin
      x.b = data[i]; x.start = (i == 0); x.len = rnr_pkg::LEN_W'(data.size());
      x.ts = ts; x.marker = mk;
      pkt_q.push_back(x);
    end
  endtask

  task automatic rand_body(inout logic [7:0] d[$], input int n);
    repeat (n) d.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_pkt(input int unsigned ts, input logic mk);
    logic [7:0] d[$];
    int k, n, sel;
    byte_t x;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      d.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(1, 23))});
      rand_body(d, $urandom_range(0, 12));
    end else if (sel < 5) begin
      d.push_back({3'($urandom_range(0, 7)), rnr_pkg::NAL_STAP_A});
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(0, 6);
        d.push_back(8'd0); d.push_back(8'(n));
        if (n > 0) begin
          d.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(1, 23))});
          rand_body(d, n - 1);
        end
      end
      if ($urandom_range(0, 4) == 0) d.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 8) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        d = {};
        d.push_back({3'($urandom_range(0, 7)),
                     ($urandom_range(0, 1) ? rnr_pkg::NAL_FU_B : rnr_pkg::NAL_FU_A)});
        d.push_back({k == 0, k == n - 1, 1'($urandom_range(0, 1)),
                     5'($urandom_range(0, 31))});
        rand_body(d, $urandom_range(0, 6));
        add_pkt(d, ts, mk && k == n - 1);
      end
      return;
    end else if (sel == 8) begin
      d.push_back(8'($urandom_range(0, 255)));
      rand_body(d, $urandom_range(0, 5));
    end else begin
      // noise: stray byte, zero length, short or truncated packet
      x.b = 8'($urandom_range(0, 255)); x.ts = $urandom();
      x.marker = 1'($urandom_range(0, 1));
      x.start = 1'($urandom_range(0, 1));
      x.len = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom());
      pkt_q.push_back(x);
      return;
    end
    add_pkt(d, ts, mk);
  endtask

  // Directed packets: payload bytes, timestamp and marker
  typedef struct {
    logic [7:0] data[$];
    int unsigned ts;
    logic mk;
  } row_t;

  // Sender: one beat per queued byte with random gaps
  task automatic send_all();
    byte_t x;
    int gap;
    while (pkt_q.size() > 0) begin
      x = pkt_q.pop_front();
      gap = $urandom_range(0, 11) * ($urandom_range(0, 2) != 0);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      payload_byte_i <= x.b; packet_start_i <= x.start; payload_length_i <= x.len;
      rtp_timestamp_i <= x.ts; marker_bit_i <= x.marker;
      do @(posedge clk_i); while (in_stall_o);
      predict_frame(x);
      @(negedge clk_i);
    end
  endtask

  // Receiver stall pattern, with one long hold-off
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_rx = 0;
      end
      w = $urandom_range(0, 2) ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted output beat with the oldest prediction
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        $error("unexpected beat kind=%0d addr=%0d", kind_o, write_address_o);
        errors++;
      end else begin
        e = frame_q.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind_o); errors++; end
        if (write_address_o !== e.addr) begin
          $error("write_address exp %0d got %0d", e.addr, write_address_o); errors++; end
        if (write_byte_o !== e.wbyte) begin
          $error("write_byte exp %0h got %0h", e.wbyte, write_byte_o); errors++; end
        if (frame_length_o !== e.flen) begin
          $error("frame_length exp %0d got %0d", e.flen, frame_length_o); errors++; end
        if (frame_timestamp_o !== e.ts) begin
          $error("frame_timestamp exp %0h got %0h", e.ts, frame_timestamp_o); errors++; end
        if (key_frame_o !== e.key) begin
          $error("key_frame exp %0d got %0d", e.key, key_frame_o); errors++; end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++; end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("rtp_h264_nal_reassembler_tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int i, n_items;
    int unsigned ts;
    fill = 0; prev_ts = 0; frag_on = 0; key_on = 0; ph = PH_IDLE; pos = 0; rem = 0;
    ind = 0; drop = 0; plen = 0; pts = 0; pmark = 0; fu_end = 0; head = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single IDR, STAP-A with empty unit, FU start/end, stray,
    // ignored type, short FU, truncated STAP-A, timestamp change
    rows.push_back('{'{8'h65, 8'hff, 8'h00}, 32'h0, 1'b0});
    rows.push_back('{'{8'h78, 8'h00, 8'h00, 8'h00, 8'h02, 8'h67, 8'h42}, 32'h0, 1'b0});
    rows.push_back('{'{8'h7c, 8'h85, 8'hab}, 32'h0, 1'b0});
    rows.push_back('{'{8'h7d, 8'h45, 8'hcd}, 32'h0, 1'b1});
    rows.push_back('{'{8'h1f, 8'h12}, 32'hffffffff, 1'b0});
    rows.push_back('{'{8'h1c}, 32'hffffffff, 1'b0});
    rows.push_back('{'{8'h18, 8'h00, 8'h09, 8'h41}, 32'hffffffff, 1'b0});
    rows.push_back('{'{8'h41, 8'h80}, 32'hffffffff, 1'b1});
    rows.push_back('{'{8'h7c, 8'h05, 8'h11}, 32'h7, 1'b1});
    foreach (rows[k]) add_pkt(rows[k].data, rows[k].ts, rows[k].mk);
    send_all();

    // Random packets; a long receiver hold-off partway through
    n_items = 0;
    ts = $urandom();
    for (i = 0; n_items < 330; i++) begin
      if ($urandom_range(0, 3) == 0) ts = $urandom_range(0, 3) ? ts + 3000 : $urandom();
      add_random_pkt(ts, $urandom_range(0, 2) == 0);
      n_items += pkt_q.size();
      if (i == 10) hold_rx = 1;
      send_all();
      if (i == 20) begin
        in_valid_i <= 1'b0;
        wait (frame_q.size() == 0);
        @(negedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    wait (frame_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && frame_q.size() == 0) $display("rtp_h264_nal_reassembler_tb OK");
    else $display("rtp_h264_nal_reassembler_tb NOT OK");
    $finish;
  end

endmodule
